### src/hsvrgb_pkg.sv
// types and constants shared by the hsv to rgb converter
`default_nettype none

package hsvrgb_pkg;

   localparam int IN_W        = 16;
   localparam int OUT_W       = 8;
   localparam int SECTOR_W    = 3;
   localparam int HUE_SECTORS = 6;
   localparam int OUT_MAX     = 255;

   typedef struct packed {
      logic [IN_W-1:0] hue;
      logic [IN_W-1:0] saturation;
      logic [IN_W-1:0] brightness;
   } hsv_pixel_type;

   typedef struct packed {
      logic [OUT_W-1:0] red;
      logic [OUT_W-1:0] green;
      logic [OUT_W-1:0] blue;
   } rgb_pixel_type;

   typedef enum logic [SECTOR_W-1:0] {
      SECTOR_RED     = 3'd0,
      SECTOR_YELLOW  = 3'd1,
      SECTOR_GREEN   = 3'd2,
      SECTOR_CYAN    = 3'd3,
      SECTOR_BLUE    = 3'd4,
      SECTOR_MAGENTA = 3'd5
   } sector_type;

   typedef struct packed {
      logic prep;
      logic weight;
      logic scale;
      logic mix;
   } stage_advance_type;

endpackage

`default_nettype wire

### src/hsvrgb_prep.sv
// first stage: fixed point conversion, hue sector and fraction
`default_nettype none

module hsvrgb_prep #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire hsvrgb_pkg::hsv_pixel_type     in_pixel,
   output logic                               out_valid,
   output logic [hsvrgb_pkg::SECTOR_W-1:0]    out_sector,
   output logic [FRAC_BITS-1:0]               out_frac,
   output logic [FRAC_BITS:0]                 out_frac_inv,
   output logic [FRAC_BITS-1:0]               out_sat,
   output logic [FRAC_BITS:0]                 out_sat_inv,
   output logic [FRAC_BITS-1:0]               out_bright
);
   import hsvrgb_pkg::*;

   localparam int FW = FRAC_BITS;
   localparam logic [FW:0] ONE = (FW+1)'(1) << FW;

   logic [FW-1:0] hue_frac;
   logic [FW-1:0] sat_frac;
   logic [FW-1:0] bright_frac;
   logic [FW+2:0] hue_six;

   logic                valid_ff, valid_in;
   logic [SECTOR_W-1:0] sector_ff, sector_in;
   logic [FW-1:0]       frac_ff, frac_in;
   logic [FW:0]         frac_inv_ff, frac_inv_in;
   logic [FW-1:0]       sat_ff;
   logic [FW:0]         sat_inv_ff, sat_inv_in;
   logic [FW-1:0]       bright_ff;

   generate
      if (FRAC_BITS >= IN_W) begin : g_widen
         assign hue_frac    = FW'(in_pixel.hue) << (FW - IN_W);
         assign sat_frac    = FW'(in_pixel.saturation) << (FW - IN_W);
         assign bright_frac = FW'(in_pixel.brightness) << (FW - IN_W);
      end else begin : g_narrow
         assign hue_frac    = FW'(in_pixel.hue >> (IN_W - FW));
         assign sat_frac    = FW'(in_pixel.saturation >> (IN_W - FW));
         assign bright_frac = FW'(in_pixel.brightness >> (IN_W - FW));
      end
   endgenerate

   always_comb begin
      hue_six     = (FW+3)'(hue_frac) * (FW+3)'(HUE_SECTORS);
      valid_in    = in_valid;
      sector_in   = hue_six[FW+2:FW];
      frac_in     = hue_six[FW-1:0];
      frac_inv_in = ONE - {1'b0, hue_six[FW-1:0]};
      sat_inv_in  = ONE - {1'b0, sat_frac};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sector_ff   <= sector_in;
         frac_ff     <= frac_in;
         frac_inv_ff <= frac_inv_in;
         sat_ff      <= sat_frac;
         sat_inv_ff  <= sat_inv_in;
         bright_ff   <= bright_frac;
      end
   end

   assign out_valid    = valid_ff;
   assign out_sector   = sector_ff;
   assign out_frac     = frac_ff;
   assign out_frac_inv = frac_inv_ff;
   assign out_sat      = sat_ff;
   assign out_sat_inv  = sat_inv_ff;
   assign out_bright   = bright_ff;

endmodule

`default_nettype wire

### src/hsvrgb_scale.sv
// second and third stages: saturation weights, then p, q and t
`default_nettype none

module hsvrgb_scale #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hsvrgb_pkg::stage_advance_type advance,
   input  wire logic                          in_valid,
   input  wire logic [hsvrgb_pkg::SECTOR_W-1:0] in_sector,
   input  wire logic [FRAC_BITS-1:0]          in_frac,
   input  wire logic [FRAC_BITS:0]            in_frac_inv,
   input  wire logic [FRAC_BITS-1:0]          in_sat,
   input  wire logic [FRAC_BITS:0]            in_sat_inv,
   input  wire logic [FRAC_BITS-1:0]          in_bright,
   output logic                               out_weight_valid,
   output logic                               out_valid,
   output logic [hsvrgb_pkg::SECTOR_W-1:0]    out_sector,
   output logic [FRAC_BITS-1:0]               out_bright,
   output logic [FRAC_BITS-1:0]               out_p,
   output logic [FRAC_BITS-1:0]               out_q,
   output logic [FRAC_BITS-1:0]               out_t
);
   import hsvrgb_pkg::*;

   localparam int FW = FRAC_BITS;
   localparam logic [FW:0] ONE = (FW+1)'(1) << FW;

   // weight stage
   logic [2*FW:0]       fs_prod, ts_prod, p_prod;
   logic                w_valid_ff;
   logic [SECTOR_W-1:0] w_sector_ff;
   logic [FW-1:0]       w_bright_ff;
   logic [FW-1:0]       w_fs_ff, w_fs_in;
   logic [FW-1:0]       w_ts_ff, w_ts_in;
   logic [FW-1:0]       w_p_ff, w_p_in;

   // product stage
   logic [FW:0]         q_weight, t_weight;
   logic [2*FW:0]       q_prod, t_prod;
   logic                s_valid_ff;
   logic [SECTOR_W-1:0] s_sector_ff;
   logic [FW-1:0]       s_bright_ff;
   logic [FW-1:0]       s_p_ff;
   logic [FW-1:0]       s_q_ff, s_q_in;
   logic [FW-1:0]       s_t_ff, s_t_in;

   always_comb begin
      fs_prod = (2*FW+1)'(in_frac) * (2*FW+1)'(in_sat);
      ts_prod = (2*FW+1)'(in_frac_inv) * (2*FW+1)'(in_sat);
      p_prod  = (2*FW+1)'(in_bright) * (2*FW+1)'(in_sat_inv);
      w_fs_in = fs_prod[2*FW-1:FW];
      w_ts_in = ts_prod[2*FW-1:FW];
      w_p_in  = p_prod[2*FW-1:FW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_valid_ff <= 1'b0;
      end else if (advance.weight) begin
         w_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance.weight) begin
         w_sector_ff <= in_sector;
         w_bright_ff <= in_bright;
         w_fs_ff     <= w_fs_in;
         w_ts_ff     <= w_ts_in;
         w_p_ff      <= w_p_in;
      end
   end

   always_comb begin
      q_weight = ONE - {1'b0, w_fs_ff};
      t_weight = ONE - {1'b0, w_ts_ff};
      q_prod   = (2*FW+1)'(w_bright_ff) * (2*FW+1)'(q_weight);
      t_prod   = (2*FW+1)'(w_bright_ff) * (2*FW+1)'(t_weight);
      s_q_in   = q_prod[2*FW-1:FW];
      s_t_in   = t_prod[2*FW-1:FW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else if (advance.scale) begin
         s_valid_ff <= w_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance.scale) begin
         s_sector_ff <= w_sector_ff;
         s_bright_ff <= w_bright_ff;
         s_p_ff      <= w_p_ff;
         s_q_ff      <= s_q_in;
         s_t_ff      <= s_t_in;
      end
   end

   assign out_weight_valid = w_valid_ff;
   assign out_valid        = s_valid_ff;
   assign out_sector       = s_sector_ff;
   assign out_bright       = s_bright_ff;
   assign out_p            = s_p_ff;
   assign out_q            = s_q_ff;
   assign out_t            = s_t_ff;

endmodule

`default_nettype wire

### src/hsvrgb_mix.sv
// last stage: sector channel selection, byte scaling and output register
`default_nettype none

module hsvrgb_mix #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          in_valid,
   input  wire logic [hsvrgb_pkg::SECTOR_W-1:0] in_sector,
   input  wire logic [FRAC_BITS-1:0]          in_bright,
   input  wire logic [FRAC_BITS-1:0]          in_p,
   input  wire logic [FRAC_BITS-1:0]          in_q,
   input  wire logic [FRAC_BITS-1:0]          in_t,
   output logic                               out_valid,
   output hsvrgb_pkg::rgb_pixel_type          out_pixel
);
   import hsvrgb_pkg::*;

   localparam int FW = FRAC_BITS;

   logic [FW-1:0]  red_ch, green_ch, blue_ch;
   logic           valid_ff;
   rgb_pixel_type  pixel_ff, pixel_in;

   function automatic logic [OUT_W-1:0] to_byte(input logic [FW-1:0] ch);
      logic [FW-1:0] scaled;
      scaled = ch >> (FW - OUT_W);
      if (scaled > FW'(OUT_MAX)) begin
         to_byte = OUT_W'(OUT_MAX);
      end else begin
         to_byte = scaled[OUT_W-1:0];
      end
   endfunction

   always_comb begin
      case (sector_type'(in_sector))
         SECTOR_RED: begin
            red_ch = in_bright; green_ch = in_t; blue_ch = in_p;
         end
         SECTOR_YELLOW: begin
            red_ch = in_q; green_ch = in_bright; blue_ch = in_p;
         end
         SECTOR_GREEN: begin
            red_ch = in_p; green_ch = in_bright; blue_ch = in_t;
         end
         SECTOR_CYAN: begin
            red_ch = in_p; green_ch = in_q; blue_ch = in_bright;
         end
         SECTOR_BLUE: begin
            red_ch = in_t; green_ch = in_p; blue_ch = in_bright;
         end
         default: begin
            red_ch = in_bright; green_ch = in_p; blue_ch = in_q;
         end
      endcase
      pixel_in.red   = to_byte(red_ch);
      pixel_in.green = to_byte(green_ch);
      pixel_in.blue  = to_byte(blue_ch);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff <= pixel_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;

endmodule

`default_nettype wire

### src/hsv_to_rgb_converter_core.sv
// hsv to rgb converter: four stage pipeline, one pixel per cycle unless the result side stalls
// a result on rsp_pixel passes the prep, weight, scale and mix registers after its input transfer
// one pixel per cycle while the result side does not stall; each of the four stages holds one pixel
// a stall on the result side holds each full stage with only full stages after it, back to the input
// reset clears the stage valid bits only; pixel data registers are not reset
`default_nettype none

module hsv_to_rgb_converter_core #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire hsvrgb_pkg::hsv_pixel_type req_pixel,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output hsvrgb_pkg::rgb_pixel_type      rsp_pixel
);
   import hsvrgb_pkg::*;

   localparam int FW = FRAC_BITS;

   stage_advance_type   advance;

   logic                prep_valid;
   logic [SECTOR_W-1:0] prep_sector;
   logic [FW-1:0]       prep_frac;
   logic [FW:0]         prep_frac_inv;
   logic [FW-1:0]       prep_sat;
   logic [FW:0]         prep_sat_inv;
   logic [FW-1:0]       prep_bright;

   logic                weight_valid;
   logic                scale_valid;
   logic [SECTOR_W-1:0] scale_sector;
   logic [FW-1:0]       scale_bright;
   logic [FW-1:0]       scale_p;
   logic [FW-1:0]       scale_q;
   logic [FW-1:0]       scale_t;

   // a stage moves when it is empty, or when the one after it is empty or moving too
   always_comb begin
      advance.mix    = !rsp_valid || !rsp_stall;
      advance.scale  = !scale_valid || advance.mix;
      advance.weight = !weight_valid || advance.scale;
      advance.prep   = !prep_valid || advance.weight;
   end

   assign req_stall = !advance.prep;

   hsvrgb_prep #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance.prep),
      .in_valid     (req_valid),
      .in_pixel     (req_pixel),
      .out_valid    (prep_valid),
      .out_sector   (prep_sector),
      .out_frac     (prep_frac),
      .out_frac_inv (prep_frac_inv),
      .out_sat      (prep_sat),
      .out_sat_inv  (prep_sat_inv),
      .out_bright   (prep_bright)
   );

   hsvrgb_scale #(
      .FRAC_BITS (FRAC_BITS)
   ) u_scale (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .in_valid         (prep_valid),
      .in_sector        (prep_sector),
      .in_frac          (prep_frac),
      .in_frac_inv      (prep_frac_inv),
      .in_sat           (prep_sat),
      .in_sat_inv       (prep_sat_inv),
      .in_bright        (prep_bright),
      .out_weight_valid (weight_valid),
      .out_valid        (scale_valid),
      .out_sector       (scale_sector),
      .out_bright       (scale_bright),
      .out_p            (scale_p),
      .out_q            (scale_q),
      .out_t            (scale_t)
   );

   hsvrgb_mix #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mix (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance.mix),
      .in_valid  (scale_valid),
      .in_sector (scale_sector),
      .in_bright (scale_bright),
      .in_p      (scale_p),
      .in_q      (scale_q),
      .in_t      (scale_t),
      .out_valid (rsp_valid),
      .out_pixel (rsp_pixel)
   );

`ifndef SYNTH
   a_no_stall_when_output_empty: assert property (
      @(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall
   ) else $error("input stalled while the output stage is empty");

   a_full_stalled_pipe_stalls_input: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && scale_valid && weight_valid && prep_valid) |-> req_stall
   ) else $error("input taken while every stage is full and stalled");

   a_sector_in_range: assert property (
      @(posedge clock) disable iff (reset)
      scale_valid |-> (scale_sector <= 3'(HUE_SECTORS - 1))
   ) else $error("hue sector above the last sector");

   a_empty_after_reset: assert property (
      @(posedge clock)
      $past(reset) |-> (!rsp_valid && !scale_valid && !prep_valid)
   ) else $error("pipeline holds a pixel straight after reset");
`endif

endmodule

`default_nettype wire

### sim/tb.sv
// testbench for the hsv to rgb converter core: random and directed pixels checked against a predictor
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hsvrgb_pkg::*;

   localparam int FRAC_BITS  = 16;
   localparam int DRAIN_STEP = 500;
   localparam int QUIET_FROM = 1200;
   localparam int QUIET_TO   = 1700;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   hsv_pixel_type req_pixel = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rgb_pixel_type rsp_pixel;

   hsv_pixel_type pending_hsv[$];
   rgb_pixel_type expected_rgb[$];
   int            mismatch_count = 0;
   int            pixels_sent = 0;
   int            drained_at = 0;
   int            cycle_count = 0;
   logic          req_taken = 1'b0;

   hsv_to_rgb_converter_core #(
      .FRAC_BITS(FRAC_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel(req_pixel),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel(rsp_pixel)
   );

   always #6 clock = ~clock;

   function automatic logic [63:0] scale_in(logic [IN_W-1:0] x);
      logic [63:0] wide;
      wide = 64'(x);
      if (FRAC_BITS >= IN_W) begin
         return wide << (FRAC_BITS - IN_W);
      end else begin
         return wide >> (IN_W - FRAC_BITS);
      end
   endfunction

   function automatic logic [OUT_W-1:0] channel_byte(logic [63:0] ch);
      logic [63:0] o;
      o = ch >> (FRAC_BITS - OUT_W);
      if (o > OUT_MAX) begin
         return OUT_W'(OUT_MAX);
      end else begin
         return o[OUT_W-1:0];
      end
   endfunction

   function automatic rgb_pixel_type predict_rgb(hsv_pixel_type px);
      logic [63:0]   one, h, s, v, h6, f, p, q, t, r, g, b;
      sector_type    sector;
      rgb_pixel_type res;
      one = 64'd1 << FRAC_BITS;
      h = scale_in(px.hue);
      s = scale_in(px.saturation);
      v = scale_in(px.brightness);
      h6 = h * HUE_SECTORS;
      f = h6 & (one - 64'd1);
      p = (v * (one - s)) >> FRAC_BITS;
      q = (v * (one - ((f * s) >> FRAC_BITS))) >> FRAC_BITS;
      t = (v * (one - (((one - f) * s) >> FRAC_BITS))) >> FRAC_BITS;
      sector = sector_type'(h6 >> FRAC_BITS);
      case (sector)
         SECTOR_RED: begin
            r = v; g = t; b = p;
         end
         SECTOR_YELLOW: begin
            r = q; g = v; b = p;
         end
         SECTOR_GREEN: begin
            r = p; g = v; b = t;
         end
         SECTOR_CYAN: begin
            r = p; g = q; b = v;
         end
         SECTOR_BLUE: begin
            r = t; g = p; b = v;
         end
         default: begin
            r = v; g = p; b = q;
         end
      endcase
      res.red   = channel_byte(r);
      res.green = channel_byte(g);
      res.blue  = channel_byte(b);
      return res;
   endfunction

   function automatic logic [IN_W-1:0] pick_field();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return IN_W'($urandom_range(255));
         3: return IN_W'(65535 - $urandom_range(255));
         default: return IN_W'($urandom);
      endcase
   endfunction

   function automatic logic [IN_W-1:0] pick_hue();
      int edge_hue;
      if ($urandom_range(3) == 0) begin
         edge_hue = ($urandom_range(1, 5) * 65536) / HUE_SECTORS + $urandom_range(4) - 2;
         return IN_W'(edge_hue);
      end else begin
         return pick_field();
      end
   endfunction

   task automatic add_pixel(logic [IN_W-1:0] h, logic [IN_W-1:0] s, logic [IN_W-1:0] v);
      hsv_pixel_type px;
      px.hue = h;
      px.saturation = s;
      px.brightness = v;
      pending_hsv.push_back(px);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic bit quiet_phase();
      return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
   endfunction

   // input driver
   always @(negedge clock) begin
      bit hold;
      bit at_drain;
      at_drain = pixels_sent != 0 && pixels_sent % DRAIN_STEP == 0 && drained_at != pixels_sent;
      if (at_drain && expected_rgb.size() == 0) begin
         drained_at <= pixels_sent;
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         hold = pending_hsv.size() == 0 || at_drain ||
                (!quiet_phase() && $urandom_range(99) < 30);
         if (hold) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_pixel <= pending_hsv.pop_front();
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet_phase() && $urandom_range(99) < 30;
      end
   end

   // monitor for both channels
   always @(posedge clock) begin
      rgb_pixel_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rgb.size() == 0) begin
            report_mismatch("unexpected result transfer, red", rsp_pixel.red, 0);
         end else begin
            want = expected_rgb.pop_front();
            if (rsp_pixel.red !== want.red)
               report_mismatch("red", rsp_pixel.red, want.red);
            if (rsp_pixel.green !== want.green)
               report_mismatch("green", rsp_pixel.green, want.green);
            if (rsp_pixel.blue !== want.blue)
               report_mismatch("blue", rsp_pixel.blue, want.blue);
         end
      end
      if (!reset && req_valid && !req_stall) begin
         expected_rgb.push_back(predict_rgb(req_pixel));
         pixels_sent <= pixels_sent + 1;
         req_taken <= 1'b1;
      end else begin
         req_taken <= 1'b0;
      end
   end

   initial begin
      rgb_pixel_type left;
      add_pixel(16'h0000, 16'h0000, 16'h0000);
      add_pixel(16'hffff, 16'hffff, 16'hffff);
      add_pixel(16'h0000, 16'hffff, 16'hffff);
      add_pixel(16'h0000, 16'h0000, 16'hffff);
      add_pixel(16'h8000, 16'hffff, 16'h0000);
      add_pixel(16'd10922, 16'hffff, 16'hffff);
      add_pixel(16'd10923, 16'hffff, 16'hffff);
      add_pixel(16'd21845, 16'hffff, 16'hffff);
      add_pixel(16'd21846, 16'hffff, 16'hffff);
      add_pixel(16'd32767, 16'hffff, 16'hffff);
      add_pixel(16'd32768, 16'hffff, 16'hffff);
      add_pixel(16'd43690, 16'hffff, 16'hffff);
      add_pixel(16'd43691, 16'hffff, 16'hffff);
      add_pixel(16'd54613, 16'hffff, 16'hffff);
      add_pixel(16'd54614, 16'hffff, 16'hffff);
      add_pixel(16'hffff, 16'h8000, 16'hc000);
      add_pixel(16'h1000, 16'h5555, 16'haaaa);
      add_pixel(16'h3000, 16'haaaa, 16'h5555);
      add_pixel(16'h5000, 16'h0001, 16'h0100);
      add_pixel(16'h7000, 16'hfffe, 16'h00ff);
      add_pixel(16'h9000, 16'h8000, 16'h8000);
      add_pixel(16'hd000, 16'h4000, 16'hffff);
      repeat (1300) add_pixel(pick_hue(), pick_field(), pick_field());

      repeat (6) @(negedge clock);
      reset = 1'b0;

      while (pending_hsv.size() != 0 || req_valid || expected_rgb.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      while (expected_rgb.size() != 0) begin
         left = expected_rgb.pop_front();
         report_mismatch("missing result, red", 0, left.red);
      end
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

### hsv_to_rgb_converter_core.f
src/hsvrgb_pkg.sv
src/hsvrgb_prep.sv
src/hsvrgb_scale.sv
src/hsvrgb_mix.sv
src/hsv_to_rgb_converter_core.sv
sim/tb.sv
